@@ src/gsn_pkg.sv @@
// Shared widths, codes and types for the gamepad sample normalizer.
`timescale 1ns / 1ps
`default_nettype none
package gsn_pkg;
    localparam int NUM_W   = 32;
    localparam int DEN_W   = 16;
    localparam int QUO_W   = 16;
    localparam int SIDE_W  = 2;
    localparam int LANE_LAT = QUO_W + 2;

    localparam logic [15:0] AXIS_POS_MAX   = 16'd32767;
    localparam logic [15:0] AXIS_NEG_MAX   = 16'd32768;
    localparam logic [15:0] TRIG_MAX       = 16'd65535;
    localparam logic [15:0] STICK_DEAD_MAX = 16'd32766;
    localparam logic [15:0] TRIG_DEAD_MAX  = 16'd65534;
    localparam logic [7:0]  BYTE_CENTRE    = 8'h80;
    localparam logic [7:0]  BYTE_FULL      = 8'hFF;

    localparam logic [1:0] CFG_LEFT_DEAD  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_DEAD = 2'd1;
    localparam logic [1:0] CFG_TRIG_DEAD  = 2'd2;

    localparam logic [2:0] KIND_FIRST_PAD = 3'd2;
    localparam logic [2:0] KIND_LAST_PAD  = 3'd5;

    typedef struct packed {
        logic        vld;
        logic        conn;
        logic        bad;
        logic [11:0] guest;
        logic        lsh;
        logic        rsh;
    } t_ctl;
endpackage
`default_nettype wire

@@ src/gsn_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module gsn_div (
    input  wire logic                        i_clk,
    input  wire logic [gsn_pkg::NUM_W-1:0]   i_num,
    input  wire logic [gsn_pkg::DEN_W-1:0]   i_den,
    input  wire logic [gsn_pkg::SIDE_W-1:0]  i_side,
    output logic      [gsn_pkg::QUO_W-1:0]   o_quo,
    output logic      [gsn_pkg::SIDE_W-1:0]  o_side
);
    localparam int Q = gsn_pkg::QUO_W;
    localparam int D = gsn_pkg::DEN_W;

    logic [D-1:0]               w_rem  [0:Q];
    logic [Q-1:0]               w_sh   [0:Q];
    logic [D-1:0]               w_den  [0:Q];
    logic [gsn_pkg::SIDE_W-1:0] w_side [0:Q];

    // quotient fits Q bits, so the upper numerator bits start below the divisor
    assign w_rem[0]  = i_num[gsn_pkg::NUM_W-1:Q];
    assign w_sh[0]   = i_num[Q-1:0];
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;

    for (genvar s = 0; s < Q; s++) begin : g_stage
        logic [D:0]                 r_try;
        logic [D:0]                 r_diff;
        logic                       r_ge;
        logic [D-1:0]               r_rem;
        logic [Q-1:0]               r_sh;
        logic [D-1:0]               r_den;
        logic [gsn_pkg::SIDE_W-1:0] r_side;

        always_comb begin
            r_try  = {w_rem[s], w_sh[s][Q-1]};
            r_diff = r_try - {1'b0, w_den[s]};
            r_ge   = r_try >= {1'b0, w_den[s]};
        end

        always_ff @(posedge i_clk) begin
            r_rem  <= r_ge ? r_diff[D-1:0] : r_try[D-1:0];
            r_sh   <= {w_sh[s][Q-2:0], r_ge};
            r_den  <= w_den[s];
            r_side <= w_side[s];
        end

        assign w_rem[s+1]  = r_rem;
        assign w_sh[s+1]   = r_sh;
        assign w_den[s+1]  = r_den;
        assign w_side[s+1] = r_side;
    end

    assign o_quo  = w_sh[Q];
    assign o_side = w_side[Q];
endmodule
`default_nettype wire

@@ src/gsn_stick_lane.sv @@
// One stick axis: deadzone, rescale to full range, map to a centred byte.
`timescale 1ns / 1ps
`default_nettype none
module gsn_stick_lane (
    input  wire logic        i_clk,
    input  wire logic [15:0] i_raw,
    input  wire logic [14:0] i_dead,
    output logic      [7:0]  o_byte
);
    logic        n_neg;
    logic [15:0] n_mag;
    logic [15:0] n_maxv;
    logic [15:0] n_dead;
    logic        n_zero;
    logic [15:0] n_diff;
    logic [31:0] r_num;
    logic [15:0] r_den;
    logic        r_neg;
    logic        r_zero;
    logic [15:0] w_quo;
    logic [1:0]  w_side;
    logic [22:0] n_x;
    logic [7:0]  n_q0;
    logic [15:0] n_rm;
    logic [7:0]  n_res;
    logic [7:0]  n_byte;
    logic [7:0]  r_byte;

    always_comb begin
        n_neg  = i_raw[15];
        n_mag  = n_neg ? 16'(17'h10000 - {1'b0, i_raw}) : i_raw;
        n_maxv = n_neg ? gsn_pkg::AXIS_NEG_MAX : gsn_pkg::AXIS_POS_MAX;
        n_dead = ({1'b0, i_dead} > gsn_pkg::STICK_DEAD_MAX) ? gsn_pkg::STICK_DEAD_MAX
                                                            : {1'b0, i_dead};
        n_zero = n_mag <= n_dead;
        n_diff = n_mag - n_dead;
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_diff * n_maxv;
        r_den  <= n_maxv - n_dead;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    gsn_div u_div (
        .i_clk  (i_clk),
        .i_num  (r_num),
        .i_den  (r_den),
        .i_side ({r_neg, r_zero}),
        .o_quo  (w_quo),
        .o_side (w_side)
    );

    // positive side: quo * 127 / 32767 via shift and one correction
    always_comb begin
        n_x   = {w_quo[15:0], 7'b0} - {7'b0, w_quo};
        n_q0  = n_x[22:15];
        n_rm  = {1'b0, n_x[14:0]} + {8'b0, n_q0};
        n_res = (n_rm >= gsn_pkg::AXIS_POS_MAX) ? n_q0 + 8'd1 : n_q0;
        if (w_side[0]) begin
            n_byte = gsn_pkg::BYTE_CENTRE;
        end else if (w_side[1]) begin
            n_byte = gsn_pkg::BYTE_CENTRE - w_quo[15:8];
        end else begin
            n_byte = gsn_pkg::BYTE_CENTRE + n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;
endmodule
`default_nettype wire

@@ src/gsn_trig_lane.sv @@
// One trigger: deadzone and rescale to 0..255.
`timescale 1ns / 1ps
`default_nettype none
module gsn_trig_lane (
    input  wire logic        i_clk,
    input  wire logic [15:0] i_raw,
    input  wire logic [15:0] i_dead,
    output logic      [7:0]  o_byte
);
    logic [15:0] n_dead;
    logic [15:0] n_diff;
    logic [31:0] r_num;
    logic [15:0] r_den;
    logic        r_zero;
    logic [15:0] w_quo;
    logic [1:0]  w_side;
    logic [7:0]  r_byte;

    always_comb begin
        n_dead = (i_dead > gsn_pkg::TRIG_DEAD_MAX) ? gsn_pkg::TRIG_DEAD_MAX : i_dead;
        n_diff = i_raw - n_dead;
    end

    always_ff @(posedge i_clk) begin
        r_num  <= {8'b0, ({n_diff, 8'b0} - {8'b0, n_diff})};
        r_den  <= gsn_pkg::TRIG_MAX - n_dead;
        r_zero <= i_raw <= n_dead;
    end

    gsn_div u_div (
        .i_clk  (i_clk),
        .i_num  (r_num),
        .i_den  (r_den),
        .i_side ({1'b0, r_zero}),
        .o_quo  (w_quo),
        .o_side (w_side)
    );

    always_ff @(posedge i_clk) begin
        r_byte <= (w_side[0] || w_side[1]) ? 8'h00 : w_quo[7:0];
    end

    assign o_byte = r_byte;
endmodule
`default_nettype wire

@@ src/gamepad_sample_normalizer.sv @@
// Top level: config registers, six parallel lanes and the merging output stage.
//
// One request is taken every clock cycle while busy is low; each result appears
// with o_valid high for one cycle, and cannot be held off. Each axis and trigger
// lane holds a product setup register, the 16-stage pipelined divider and a byte
// scaling register, and a final merge register follows. busy is high only during
// and just after reset.
`timescale 1ns / 1ps
`default_nettype none
module gamepad_sample_normalizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_is_connected,
    input  wire logic [2:0]  i_device_kind,
    input  wire logic [63:0] i_device_ident,
    input  wire logic [15:0] i_host_buttons,
    input  wire logic signed [15:0] i_left_axis_x,
    input  wire logic signed [15:0] i_left_axis_y,
    input  wire logic signed [15:0] i_right_axis_x,
    input  wire logic signed [15:0] i_right_axis_y,
    input  wire logic [15:0] i_left_trig_raw,
    input  wire logic [15:0] i_right_trig_raw,
    output logic             o_valid,
    output logic      [11:0] o_guest_buttons,
    output logic      [7:0]  o_left_trig_out,
    output logic      [7:0]  o_right_trig_out,
    output logic      [7:0]  o_stick1_x,
    output logic      [7:0]  o_stick1_y,
    output logic      [7:0]  o_stick2_x,
    output logic      [7:0]  o_stick2_y,
    output logic             o_bad_sample
);
    localparam int LAT = gsn_pkg::LANE_LAT;

    logic [14:0]     r_left_dead;
    logic [14:0]     r_right_dead;
    logic [15:0]     r_trig_dead;
    logic            r_rdy;
    logic            w_accept;
    gsn_pkg::t_ctl   n_ctl;
    gsn_pkg::t_ctl   r_ctl [0:LAT-1];
    logic [7:0]      w_lt, w_rt, w_s1x, w_s1y, w_s2x, w_s2y;
    logic            w_ok;

    assign busy     = !r_rdy;
    assign w_accept = start && r_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_dead  <= '0;
            r_right_dead <= '0;
            r_trig_dead  <= '0;
            r_rdy        <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gsn_pkg::CFG_LEFT_DEAD:  r_left_dead  <= i_cfg_data[14:0];
                    gsn_pkg::CFG_RIGHT_DEAD: r_right_dead <= i_cfg_data[14:0];
                    gsn_pkg::CFG_TRIG_DEAD:  r_trig_dead  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_ctl.vld   = w_accept;
        n_ctl.conn  = i_is_connected;
        n_ctl.bad   = i_is_connected && ((i_device_ident == 64'd0)
                      || (i_device_kind < gsn_pkg::KIND_FIRST_PAD)
                      || (i_device_kind > gsn_pkg::KIND_LAST_PAD)
                      || (i_host_buttons[15:14] != 2'b00));
        n_ctl.guest = {i_host_buttons[13:12], i_host_buttons[9:0]};
        n_ctl.lsh   = i_host_buttons[10];
        n_ctl.rsh   = i_host_buttons[11];
    end

    // hold request control alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_ctl[k].vld <= 1'b0;
            end
        end else begin
            r_ctl[0].vld <= n_ctl.vld;
            for (int k = 1; k < LAT; k++) begin
                r_ctl[k].vld <= r_ctl[k-1].vld;
            end
        end
        r_ctl[0].conn  <= n_ctl.conn;
        r_ctl[0].bad   <= n_ctl.bad;
        r_ctl[0].guest <= n_ctl.guest;
        r_ctl[0].lsh   <= n_ctl.lsh;
        r_ctl[0].rsh   <= n_ctl.rsh;
        for (int k = 1; k < LAT; k++) begin
            r_ctl[k].conn  <= r_ctl[k-1].conn;
            r_ctl[k].bad   <= r_ctl[k-1].bad;
            r_ctl[k].guest <= r_ctl[k-1].guest;
            r_ctl[k].lsh   <= r_ctl[k-1].lsh;
            r_ctl[k].rsh   <= r_ctl[k-1].rsh;
        end
    end

    gsn_stick_lane u_s1x (.i_clk(i_clk), .i_raw(i_left_axis_x),  .i_dead(r_left_dead),
                          .o_byte(w_s1x));
    gsn_stick_lane u_s1y (.i_clk(i_clk), .i_raw(i_left_axis_y),  .i_dead(r_left_dead),
                          .o_byte(w_s1y));
    gsn_stick_lane u_s2x (.i_clk(i_clk), .i_raw(i_right_axis_x), .i_dead(r_right_dead),
                          .o_byte(w_s2x));
    gsn_stick_lane u_s2y (.i_clk(i_clk), .i_raw(i_right_axis_y), .i_dead(r_right_dead),
                          .o_byte(w_s2y));
    gsn_trig_lane  u_lt  (.i_clk(i_clk), .i_raw(i_left_trig_raw),  .i_dead(r_trig_dead),
                          .o_byte(w_lt));
    gsn_trig_lane  u_rt  (.i_clk(i_clk), .i_raw(i_right_trig_raw), .i_dead(r_trig_dead),
                          .o_byte(w_rt));

    assign w_ok = r_ctl[LAT-1].conn && !r_ctl[LAT-1].bad;

    // merge: zero the buttons, triggers and sticks for a disconnected or bad sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_ctl[LAT-1].vld;
        end
        o_bad_sample     <= r_ctl[LAT-1].bad;
        o_guest_buttons  <= w_ok ? r_ctl[LAT-1].guest : 12'd0;
        o_left_trig_out  <= !w_ok ? 8'd0 : (r_ctl[LAT-1].lsh ? gsn_pkg::BYTE_FULL : w_lt);
        o_right_trig_out <= !w_ok ? 8'd0 : (r_ctl[LAT-1].rsh ? gsn_pkg::BYTE_FULL : w_rt);
        o_stick1_x       <= w_ok ? w_s1x : 8'd0;
        o_stick1_y       <= w_ok ? w_s1y : 8'd0;
        o_stick2_x       <= w_ok ? w_s2x : 8'd0;
        o_stick2_y       <= w_ok ? w_s2y : 8'd0;
    end
endmodule
`default_nettype wire

@@ src/gsn_checker.sv @@
// Port-level checks for the normalizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gsn_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [11:0] o_guest_buttons,
    input wire logic [7:0]  o_left_trig_out,
    input wire logic [7:0]  o_stick1_x,
    input wire logic        o_bad_sample
);
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##19 o_valid)
        else $error("request did not produce a result after 19 cycles");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_sample) |->
        (o_guest_buttons == 12'd0 && o_left_trig_out == 8'd0 && o_stick1_x == 8'd0))
        else $error("bad sample carried nonzero fields");

    a_ready_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !busy)
        else $error("busy rose outside reset");
endmodule

bind gamepad_sample_normalizer gsn_checker u_gsn_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_guest_buttons (o_guest_buttons),
    .o_left_trig_out (o_left_trig_out),
    .o_stick1_x      (o_stick1_x),
    .o_bad_sample    (o_bad_sample)
);
`default_nettype wire

@@ dv/gamepad_sample_normalizer_tb.sv @@
// Self-checking testbench for the gamepad sample normalizer.
`timescale 1ns / 1ps
`default_nettype none
module gamepad_sample_normalizer_tb;
    typedef struct packed {
        logic        conn;
        logic [2:0]  kind;
        logic [63:0] ident;
        logic [15:0] btn;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [15:0] lt;
        logic [15:0] rt;
    } t_sample;

    typedef struct packed {
        logic [11:0] guest;
        logic [7:0]  lt;
        logic [7:0]  rt;
        logic [7:0]  s1x;
        logic [7:0]  s1y;
        logic [7:0]  s2x;
        logic [7:0]  s2y;
        logic        bad;
    } t_state;

    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    t_sample     drv;
    logic        o_valid;
    t_state      got;

    t_sample pending_samples[$];
    t_state  expected_states[$];
    logic [15:0] left_dead, right_dead, trig_dead;
    int  errors;
    int  cycles;
    bit  quiet_stretch;
    logic took;

    gamepad_sample_normalizer u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_is_connected(drv.conn), .i_device_kind(drv.kind),
        .i_device_ident(drv.ident), .i_host_buttons(drv.btn),
        .i_left_axis_x(drv.lx), .i_left_axis_y(drv.ly),
        .i_right_axis_x(drv.rx), .i_right_axis_y(drv.ry),
        .i_left_trig_raw(drv.lt), .i_right_trig_raw(drv.rt),
        .o_valid(o_valid), .o_guest_buttons(got.guest),
        .o_left_trig_out(got.lt), .o_right_trig_out(got.rt),
        .o_stick1_x(got.s1x), .o_stick1_y(got.s1y),
        .o_stick2_x(got.s2x), .o_stick2_y(got.s2y),
        .o_bad_sample(got.bad)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] axis_byte(logic [15:0] raw, logic [15:0] dead_cfg);
        logic        neg;
        logic [31:0] mag, maxv, dead, scaled;
        neg = raw[15];
        mag = neg ? (32'h10000 - raw) : {16'd0, raw};
        maxv = neg ? 32'd32768 : 32'd32767;
        dead = (dead_cfg > gsn_pkg::STICK_DEAD_MAX) ? 32'(gsn_pkg::STICK_DEAD_MAX)
                                                    : {16'd0, dead_cfg};
        if (mag <= dead) return gsn_pkg::BYTE_CENTRE;
        scaled = 32'((64'(mag - dead) * maxv) / (maxv - dead));
        if (neg) return 8'(32'h80 - (scaled * 32'h80) / 32'd32768);
        return 8'(32'h80 + (scaled * 32'h7F) / 32'd32767);
    endfunction

    function automatic logic [7:0] trigger_level(logic [15:0] raw, logic [15:0] dead_cfg);
        logic [31:0] dead;
        dead = (dead_cfg > gsn_pkg::TRIG_DEAD_MAX) ? 32'(gsn_pkg::TRIG_DEAD_MAX)
                                                   : {16'd0, dead_cfg};
        if ({16'd0, raw} <= dead) return 8'd0;
        return 8'((({16'd0, raw} - dead) * 32'hFF) / (32'd65535 - dead));
    endfunction

    function automatic t_state normalize(t_sample s);
        t_state r;
        r = '0;
        if (!s.conn) return r;
        if (s.ident == 64'd0 || s.kind < gsn_pkg::KIND_FIRST_PAD
                || s.kind > gsn_pkg::KIND_LAST_PAD || s.btn[15:14] != 2'b00) begin
            r.bad = 1'b1;
            return r;
        end
        r.guest = {s.btn[13:12], s.btn[9:0]};
        r.lt = s.btn[10] ? gsn_pkg::BYTE_FULL : trigger_level(s.lt, trig_dead);
        r.rt = s.btn[11] ? gsn_pkg::BYTE_FULL : trigger_level(s.rt, trig_dead);
        r.s1x = axis_byte(s.lx, left_dead);
        r.s1y = axis_byte(s.ly, left_dead);
        r.s2x = axis_byte(s.rx, right_dead);
        r.s2y = axis_byte(s.ry, right_dead);
        return r;
    endfunction

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        s.conn  = ($urandom_range(0, 19) != 0);
        s.kind  = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(2, 5));
        s.ident = ($urandom_range(0, 29) == 0) ? 64'd0 : {$urandom, $urandom};
        s.btn   = 16'($urandom) & (($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'h3FFF);
        s.lx = pick_axis();
        s.ly = pick_axis();
        s.rx = pick_axis();
        s.ry = pick_axis();
        s.lt = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
        s.rt = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
        return s;
    endfunction

    function automatic t_sample good_sample(logic [15:0] btn, logic [15:0] ax,
                                            logic [15:0] trig);
        t_sample s;
        s = '{conn: 1'b1, kind: 3'd2, ident: 64'd1, btn: btn, lx: ax, ly: ax,
              rx: ax, ry: ax, lt: trig, rt: trig};
        return s;
    endfunction

    task automatic queue_sample(t_sample s);
        pending_samples = {pending_samples, s};
    endtask

    // Driver: present the head of the queue; advance only on an accepted request.
    always @(negedge i_clk) begin
        if (took)
            void'(pending_samples.pop_front());
        if (pending_samples.size() != 0 && (quiet_stretch || $urandom_range(0, 99) >= 15)) begin
            start <= 1'b1;
            drv   <= pending_samples[0];
        end else begin
            start <= 1'b0;
            drv   <= random_sample();
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        took   <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy)
            expected_states = {expected_states, normalize(drv)};
        if (i_rst_n && o_valid) begin
            if (expected_states.size() == 0) begin
                $display("%0t: result with no request pending: %h", $time, got);
                errors++;
            end else begin
                if (got !== expected_states[0]) begin
                    $display("%0t: mismatch expected %h actual %h", $time,
                             expected_states[0], got);
                    errors++;
                end
                void'(expected_states.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            gsn_pkg::CFG_LEFT_DEAD:  left_dead  = val & 16'h7FFF;
            gsn_pkg::CFG_RIGHT_DEAD: right_dead = val & 16'h7FFF;
            default:                 trig_dead  = val;
        endcase
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && expected_states.size() == 0);
        repeat (gsn_pkg::LANE_LAT + 4) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] axes[6];
        axes = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h4000};
        errors = 0;
        cycles = 0;
        took = 1'b0;
        quiet_stretch = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        drv = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = gsn_pkg::CFG_LEFT_DEAD;
        i_cfg_data = '0;
        left_dead = '0;
        right_dead = '0;
        trig_dead = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: axis extremes, shoulders, remap, disconnect, invalid cases.
        foreach (axes[k])
            queue_sample(good_sample(16'h3FFF & 16'(k * 16'h0A5F), axes[k],
                                     16'(k * 16'h3333)));
        queue_sample(good_sample(16'h0C00, 16'h1234, 16'h0000));
        queue_sample(good_sample(16'h3000, 16'hEDCC, 16'hFFFF));
        begin
            t_sample s;
            s = good_sample(16'h3FFF, 16'h7FFF, 16'hFFFF);
            s.conn = 1'b0;
            queue_sample(s);
            s.conn = 1'b1; s.ident = 64'd0;
            queue_sample(s);
            s.ident = 64'hFFFF_FFFF_FFFF_FFFF;
            for (int k = 0; k < 8; k++) begin
                s.kind = 3'(k);
                queue_sample(s);
            end
            s.kind = 3'd5; s.btn = 16'h4000;
            queue_sample(s);
            s.btn = 16'h8000;
            queue_sample(s);
        end
        drain();

        // Phases across deadzone settings, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(gsn_pkg::CFG_LEFT_DEAD, 16'd32767);
                    write_reg(gsn_pkg::CFG_RIGHT_DEAD, 16'd32766);
                    write_reg(gsn_pkg::CFG_TRIG_DEAD, 16'd65535);
                end
                1: begin
                    write_reg(gsn_pkg::CFG_LEFT_DEAD, 16'd0);
                    write_reg(gsn_pkg::CFG_RIGHT_DEAD, 16'd0);
                    write_reg(gsn_pkg::CFG_TRIG_DEAD, 16'd0);
                end
                2: begin
                    write_reg(gsn_pkg::CFG_LEFT_DEAD, 16'hFFFF);
                    write_reg(gsn_pkg::CFG_RIGHT_DEAD, 16'd1);
                    write_reg(gsn_pkg::CFG_TRIG_DEAD, 16'd65534);
                end
                default: begin
                    write_reg(gsn_pkg::CFG_LEFT_DEAD, 16'($urandom));
                    write_reg(gsn_pkg::CFG_RIGHT_DEAD, 16'($urandom_range(0, 4000)));
                    write_reg(gsn_pkg::CFG_TRIG_DEAD, 16'($urandom));
                end
            endcase
            quiet_stretch = (ph == 3);
            for (int n = 0; n < 190; n++)
                queue_sample(random_sample());
            drain();
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
